FILE: design/dlefr_pkg.sv
// Package for the DLE frame receiver: byte codes, reply codes and the
// per-beat frame status struct. No dependencies.
package dlefr_pkg;

   localparam logic [7:0] DLE_BYTE = 8'h10;
   localparam logic [7:0] ETX_BYTE = 8'h03;
   localparam logic [7:0] ACK_ID = 8'h06;
   localparam logic [7:0] TRAILER_SUM = 8'h13;
   localparam logic [3:0] NAK_LIMIT_RESET = 4'd7;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_ACK  = 2'd1,
      REPLY_NAK  = 2'd2
   } reply_type;

   typedef struct packed {
      logic       produce;
      logic       frame_end;
      logic       checksum_good;
      logic       overflow;
      logic [7:0] packet_id;
      logic [8:0] position;
   } frame_info_type;

endpackage

FILE: design/dlefr_framer.sv
// Frame tracker: DLE unstuffing, byte position, running checksum and id.
// Depends on dlefr_pkg.
module dlefr_framer #(
   parameter int MAX_FRAME = 512
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   output dlefr_pkg::frame_info_type info
);
   import dlefr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       prev_ff, prev_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       id_ff, id_in;

   logic             drop, ovf, frame_end;
   logic [CNT_W-1:0] pos;
   logic [7:0]       sum_eff, id_eff, sum_new, id_new;
   logic [CNT_W+8:0] pos_wide;

   always_comb begin
      drop      = (rx_byte == DLE_BYTE) && (prev_ff == DLE_BYTE);
      ovf       = (count_ff >= CNT_W'(MAX_FRAME));
      pos       = ovf ? '0 : count_ff;
      sum_eff   = ovf ? 8'h00 : sum_ff;
      id_eff    = ovf ? 8'h00 : id_ff;
      frame_end = !ovf && (rx_byte == ETX_BYTE) && (prev_ff == DLE_BYTE);
      sum_new   = (pos != '0) ? 8'(sum_eff + rx_byte) : sum_eff;
      id_new    = (pos == CNT_W'(1)) ? rx_byte : id_eff;
      pos_wide  = {9'd0, pos};

      info.produce       = !drop;
      info.frame_end     = frame_end;
      info.checksum_good = (pos >= CNT_W'(3)) && (sum_new == TRAILER_SUM);
      info.overflow      = ovf;
      info.packet_id     = id_new;
      info.position      = pos_wide[8:0];

      count_in = count_ff;
      prev_in  = prev_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      if (step) begin
         if (drop) begin
            prev_in = 8'h00;
         end else if (frame_end) begin
            count_in = '0;
            prev_in  = 8'h00;
            sum_in   = 8'h00;
            id_in    = 8'h00;
         end else begin
            count_in = CNT_W'(pos + 1'b1);
            prev_in  = rx_byte;
            sum_in   = sum_new;
            id_in    = id_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_ff  <= 8'h00;
         sum_ff   <= 8'h00;
         id_ff    <= 8'h00;
      end else begin
         count_ff <= count_in;
         prev_ff  <= prev_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
      end
   end

endmodule

FILE: design/dle_frame_receiver_core.sv
// Top level of the DLE frame receiver: handshakes, NAK counter, result register.
// Depends on dlefr_pkg and dlefr_framer.
//
//  channel  ports                       direction  beat moves
//  req      req_valid/req_stall         in         one raw serial byte
//  rsp      rsp_valid/rsp_stall         out        one stored byte with frame status
//  csr      csr_wr_en/csr_wr_data       in         nak_limit, 4 bits
//
// One byte per cycle unless req_stall; a result shows the cycle after its beat.
// A dropped second DLE gives no rsp beat. The result register is the only
// buffer: req_stall rises only while a result waits and rsp_stall is high.
// Synchronous reset clears frame state, NAK count and sets nak_limit to 7.
module dle_frame_receiver_core #(
   parameter int MAX_FRAME = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic [8:0] rsp_byte_position,
   output logic       rsp_frame_end,
   output logic       rsp_checksum_good,
   output logic [7:0] rsp_packet_id,
   output logic [1:0] rsp_reply_kind,
   output logic       rsp_nak_abort,
   output logic       rsp_overflow,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data
);
   import dlefr_pkg::*;

   logic           accept;
   frame_info_type info;

   logic [3:0] nak_limit_ff, nak_limit_in;
   logic [3:0] nak_count_ff, nak_count_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] data_ff, id_ff;
   logic [8:0] pos_ff;
   logic       end_ff, good_ff, abort_ff, ovf_ff, abort_in;
   reply_type  reply_ff, reply_in;
   logic [3:0] limit_eff;
   logic [4:0] cnt_next;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   dlefr_framer #(
      .MAX_FRAME(MAX_FRAME)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .rx_byte(req_rx_byte),
      .info   (info)
   );

   always_comb begin
      nak_limit_in = csr_wr_en ? csr_wr_data : nak_limit_ff;
      limit_eff    = (nak_limit_ff == 4'd0) ? 4'd1 : nak_limit_ff;
      cnt_next     = {1'b0, nak_count_ff} + 5'd1;
      reply_in     = REPLY_NONE;
      abort_in     = 1'b0;
      nak_count_in = nak_count_ff;
      if (info.frame_end) begin
         if (info.checksum_good) begin
            reply_in = (info.packet_id != ACK_ID) ? REPLY_ACK : REPLY_NONE;
         end else begin
            reply_in = REPLY_NAK;
            abort_in = (cnt_next >= {1'b0, limit_eff});
         end
      end
      if (accept && info.produce && info.frame_end) begin
         if (info.checksum_good) begin
            nak_count_in = 4'd0;
         end else begin
            nak_count_in = abort_in ? 4'd0 : cnt_next[3:0];
         end
      end
      if (accept) begin
         rsp_valid_in = info.produce;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nak_limit_ff <= NAK_LIMIT_RESET;
         nak_count_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         nak_limit_ff <= nak_limit_in;
         nak_count_ff <= nak_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && info.produce) begin
         data_ff  <= req_rx_byte;
         pos_ff   <= info.position;
         end_ff   <= info.frame_end;
         good_ff  <= info.frame_end && info.checksum_good;
         id_ff    <= info.frame_end ? info.packet_id : 8'h00;
         reply_ff <= reply_in;
         abort_ff <= abort_in;
         ovf_ff   <= info.overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = data_ff;
   assign rsp_byte_position = pos_ff;
   assign rsp_frame_end     = end_ff;
   assign rsp_checksum_good = good_ff;
   assign rsp_packet_id     = id_ff;
   assign rsp_reply_kind    = reply_ff;
   assign rsp_nak_abort     = abort_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for dle_frame_receiver_core: DLE unstuffing, trailer detection,
// checksum verdict, ACK/NAK reply, NAK abort and overflow restart under random idling.
// Depends on dlefr_pkg and the receiver RTL; all stimulus is generated here.
module tb_top;
   import dlefr_pkg::*;

   localparam int FRAME_CAP = 512;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_BYTES = 140;
   localparam int NUM_PHASES = 4;
   localparam int PHASE_LIMIT [NUM_PHASES] = '{1, 15, 0, 3};
   localparam int PHASE_IDLE [NUM_PHASES] = '{83, 0, 28, 0};
   localparam int PHASE_STALL [NUM_PHASES] = '{0, 83, 28, 0};

   typedef struct packed {
      logic [7:0] data_byte;
      logic [8:0] position;
      logic       frame_end;
      logic       checksum_good;
      logic [7:0] packet_id;
      reply_type  reply;
      logic       nak_abort;
      logic       overflow;
   } rx_result_type;

   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;
      rx_result_type want;
   } stim_row_type;

   // typed rows carry their result; the others go through the predictor
   localparam stim_row_type DIRECTED_ROWS [26] = '{
      // minimal good frame, id 0 -> ACK
      '{8'hFF, 1'b1, '{8'hFF, 9'd0, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{8'h00, 1'b1, '{8'h00, 9'd1, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{DLE_BYTE, 1'b1, '{DLE_BYTE, 9'd2, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{ETX_BYTE, 1'b1, '{ETX_BYTE, 9'd3, 1'b1, 1'b1, 8'h00, REPLY_ACK, 1'b0, 1'b0}},
      // good frame carrying the ACK id -> no reply
      '{8'h00, 1'b0, '0},
      '{ACK_ID, 1'b0, '0},
      '{8'hFA, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{ETX_BYTE, 1'b0, '0},
      // doubled DLE inside the body
      '{8'h00, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{8'hF0, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{ETX_BYTE, 1'b0, '0},
      // trailer only: too short, NAK
      '{DLE_BYTE, 1'b1, '{DLE_BYTE, 9'd0, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{ETX_BYTE, 1'b1, '{ETX_BYTE, 9'd1, 1'b1, 1'b0, ETX_BYTE, REPLY_NAK, 1'b0, 1'b0}},
      // bad checksum, all-ones bytes
      '{8'hFF, 1'b1, '{8'hFF, 9'd0, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, '{8'hFF, 9'd1, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{DLE_BYTE, 1'b1, '{DLE_BYTE, 9'd2, 1'b0, 1'b0, 8'h00, REPLY_NONE, 1'b0, 1'b0}},
      '{ETX_BYTE, 1'b1, '{ETX_BYTE, 9'd3, 1'b1, 1'b0, 8'hFF, REPLY_NAK, 1'b0, 1'b0}},
      // ETX after a dropped DLE does not close the frame
      '{DLE_BYTE, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{ETX_BYTE, 1'b0, '0},
      '{DLE_BYTE, 1'b0, '0},
      '{ETX_BYTE, 1'b0, '0}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic [8:0] rsp_byte_position;
   logic       rsp_frame_end;
   logic       rsp_checksum_good;
   logic [7:0] rsp_packet_id;
   logic [1:0] rsp_reply_kind;
   logic       rsp_nak_abort;
   logic       rsp_overflow;
   logic       csr_wr_en;
   logic [3:0] csr_wr_data;

   // receiver model state
   logic [7:0]  last_stored;
   int unsigned stored_cnt;
   logic [7:0]  frame_sum;
   logic [7:0]  frame_ident;
   logic [3:0]  naks_in_row;
   logic [3:0]  nak_limit_q;

   rx_result_type pending_results [$];
   logic [7:0] burst [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int fail_cnt = 0;
   int bytes_sent = 0;
   int results_seen = 0;
   int frames_seen = 0;
   int aborts_seen = 0;
   int overflow_seen = 0;
   int quiet_cycles = 0;

   dle_frame_receiver_core #(.MAX_FRAME(FRAME_CAP)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_checksum_good (rsp_checksum_good),
      .rsp_packet_id     (rsp_packet_id),
      .rsp_reply_kind    (rsp_reply_kind),
      .rsp_nak_abort     (rsp_nak_abort),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_frame();
      stored_cnt = 0;
      frame_sum = 8'h00;
      frame_ident = 8'h00;
      last_stored = 8'h00;
   endfunction

   // returns 1 when the byte is stored and gives a result beat
   function automatic bit deframe_byte(input logic [7:0] b, output rx_result_type r);
      int unsigned pos;
      int unsigned lim;
      int unsigned cnt;
      bit          ovf;
      r = '0;
      if (b == DLE_BYTE && last_stored == DLE_BYTE) begin
         last_stored = 8'h00;
         return 1'b0;
      end
      ovf = 1'b0;
      if (stored_cnt >= FRAME_CAP) begin
         clear_frame();
         ovf = 1'b1;
      end
      pos = stored_cnt;
      r.frame_end = !ovf && b == ETX_BYTE && last_stored == DLE_BYTE;
      if (pos >= 1) frame_sum = frame_sum + b;
      if (pos == 1) frame_ident = b;
      stored_cnt = pos + 1;
      last_stored = b;
      r.data_byte = b;
      r.position = pos[8:0];
      r.overflow = ovf;
      if (r.frame_end) begin
         r.packet_id = frame_ident;
         if (pos + 1 >= 4 && frame_sum == TRAILER_SUM) begin
            r.checksum_good = 1'b1;
            r.reply = (frame_ident != ACK_ID) ? REPLY_ACK : REPLY_NONE;
            naks_in_row = 4'd0;
         end else begin
            lim = (nak_limit_q == 4'd0) ? 1 : nak_limit_q;
            cnt = naks_in_row + 1;
            r.reply = REPLY_NAK;
            if (cnt >= lim) begin
               r.nak_abort = 1'b1;
               naks_in_row = 4'd0;
            end else begin
               naks_in_row = cnt[3:0];
            end
         end
         clear_frame();
      end
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input logic [8:0] exp_v,
                              input logic [8:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         fail_cnt++;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic typed, input rx_result_type want);
      rx_result_type r;
      if (deframe_byte(b, r)) pending_results.push_back(typed ? want : r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic stuff(input logic [7:0] b);
      burst.push_back(b);
      if (b == DLE_BYTE) burst.push_back(DLE_BYTE);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return DLE_BYTE;
         1: return ETX_BYTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // stuffed frame with a checksum byte that is right three times in four
   task automatic build_frame();
      logic [7:0] id;
      logic [7:0] b;
      logic [7:0] sum;
      int         n;
      stuff(pick_byte());
      id = ($urandom_range(5) == 0) ? ACK_ID : pick_byte();
      stuff(id);
      sum = id;
      n = ($urandom_range(15) == 0) ? $urandom_range(60) : $urandom_range(8);
      repeat (n) begin
         b = pick_byte();
         stuff(b);
         sum = sum + b;
      end
      b = -sum;
      if ($urandom_range(3) == 0) b = b + 8'($urandom_range(1, 255));
      stuff(b);
      burst.push_back(DLE_BYTE);
      burst.push_back(ETX_BYTE);
   endtask

   task automatic run_random(input int target);
      int start_cnt;
      int kind;
      int cut;
      start_cnt = bytes_sent;
      while (bytes_sent - start_cnt < target) begin
         kind = $urandom_range(99);
         burst.delete();
         if (kind < 75) begin
            build_frame();
            if (kind >= 62) begin
               cut = $urandom_range(1, burst.size() - 1);
               while (burst.size() > cut) void'(burst.pop_back());
            end
         end else if (kind < 87) begin
            repeat ($urandom_range(2)) stuff(pick_byte());
            burst.push_back(DLE_BYTE);
            burst.push_back(ETX_BYTE);
         end else begin
            repeat ($urandom_range(1, 6)) burst.push_back(pick_byte());
         end
         foreach (burst[i]) send_byte(burst[i], 1'b0, '0);
      end
   endtask

   // fills the buffer to the last slot with a DLE there, so the ETX that
   // follows must restart the frame instead of closing it
   task automatic run_overlong();
      logic [7:0] b;
      repeat (FRAME_CAP - 1) begin
         b = 8'($urandom_range(255));
         if (b == DLE_BYTE) b = ETX_BYTE;
         send_byte(b, 1'b0, '0);
      end
      send_byte(DLE_BYTE, 1'b0, '0);
      send_byte(ETX_BYTE, 1'b0, '0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_nak_limit(input logic [3:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      nak_limit_q = value;
   endtask

   always @(posedge clock) begin
      rx_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: data_byte %0h, position %0d",
                   rsp_data_byte, rsp_byte_position);
            fail_cnt++;
         end else begin
            want = pending_results.pop_front();
            check_field("data_byte", 9'(want.data_byte), 9'(rsp_data_byte));
            check_field("byte_position", want.position, rsp_byte_position);
            check_field("frame_end", 9'(want.frame_end), 9'(rsp_frame_end));
            check_field("checksum_good", 9'(want.checksum_good),
                        9'(rsp_checksum_good));
            check_field("packet_id", 9'(want.packet_id), 9'(rsp_packet_id));
            check_field("reply_kind", 9'(want.reply), 9'(rsp_reply_kind));
            check_field("nak_abort", 9'(want.nak_abort), 9'(rsp_nak_abort));
            check_field("overflow", 9'(want.overflow), 9'(rsp_overflow));
            results_seen++;
            if (want.frame_end) frames_seen++;
            if (want.nak_abort) aborts_seen++;
            if (want.overflow) overflow_seen++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int ph;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_wr_en <= 1'b0;
      csr_wr_data <= 4'd0;
      nak_limit_q = NAK_LIMIT_RESET;
      naks_in_row = 4'd0;
      clear_frame();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      run_overlong();
      run_random(PHASE_BYTES);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         write_nak_limit(4'(PHASE_LIMIT[ph]));
         idle_pct = PHASE_IDLE[ph];
         stall_pct = PHASE_STALL[ph];
         run_random(PHASE_BYTES);
      end

      settle();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes; checked %0d result beats, %0d closed frames,",
               bytes_sent, results_seen, frames_seen);
      $display("%0d NAK aborts and %0d overflow restarts across five NAK limits.",
               aborts_seen, overflow_seen);
      if (fail_cnt == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
